// ===== hdl/vtsec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtsec_pkg
// Shared widths, codes and types of the VT single-error corrector.
// ----------------------------------------------------------------------------
package vtsec_pkg;

   localparam int MAX_LEN    = 1024;
   localparam int WORD_DEPTH = MAX_LEN + 1;
   localparam int ADDR_W     = $clog2(WORD_DEPTH);
   localparam int LEN_W      = 11;
   localparam int MOD_W      = LEN_W + 1;
   localparam int STEP_W     = $clog2(MOD_W);

   typedef enum logic [2:0] {
      STATUS_OK     = 3'd0,
      STATUS_CLEAR  = 3'd1,
      STATUS_REMOVE = 3'd2,
      STATUS_INSERT = 3'd3,
      STATUS_FAIL   = 3'd4
   } vtsec_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_DECIDE,
      ST_CHECK_CLEAR,
      ST_SCAN,
      ST_EMIT
   } vtsec_state_type;

   typedef enum logic {
      MODE_REMOVE,
      MODE_INSERT
   } vtsec_mode_type;

   typedef struct packed {
      logic             start;
      logic [MOD_W-1:0] operand;
      logic [MOD_W-1:0] modulus;
   } vtsec_mod_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] remainder;
   } vtsec_mod_rsp_type;

   typedef struct packed {
      vtsec_mode_type   mode;
      logic             bit_value;
      logic [LEN_W-1:0] syndrome;
      logic [LEN_W-1:0] ones;
      logic [LEN_W-1:0] ones_before;
      logic [LEN_W-1:0] index;
      logic [MOD_W-1:0] modulus;
   } vtsec_scan_in_type;

   typedef struct packed {
      logic hit;
      logic inserted;
   } vtsec_scan_out_type;

endpackage

// ===== hdl/vtsec_mod_reduce.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtsec_mod_reduce
// Shared modulo unit: one compare-subtract when the operand is below twice
// the modulus, otherwise a restoring remainder, one bit per cycle.
// ----------------------------------------------------------------------------
module vtsec_mod_reduce (
   input  logic                        clock,
   input  logic                        reset,
   input  vtsec_pkg::vtsec_mod_req_type mod_req,
   output vtsec_pkg::vtsec_mod_rsp_type mod_rsp
);
   import vtsec_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MOD_W-1:0]  rem_ff, rem_in;
   logic [MOD_W-1:0]  opnd_ff, opnd_in;
   logic [MOD_W-1:0]  mod_ff, mod_in;
   logic [MOD_W-1:0]  diff;
   logic [MOD_W-1:0]  shifted;

   assign diff    = mod_req.operand - mod_req.modulus;
   assign shifted = {rem_ff[MOD_W-2:0], opnd_ff[step_ff]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      opnd_in = opnd_ff;
      mod_in  = mod_ff;
      if (mod_req.start) begin
         opnd_in = mod_req.operand;
         mod_in  = mod_req.modulus;
         if (mod_req.operand < mod_req.modulus) begin
            rem_in  = mod_req.operand;
            done_in = 1'b1;
         end else if (diff < mod_req.modulus) begin
            rem_in  = diff;
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
            rem_in  = '0;
            step_in = STEP_W'(MOD_W - 1);
         end
      end else if (busy_ff) begin
         rem_in = (shifted >= mod_ff) ? shifted - mod_ff : shifted;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      opnd_ff <= opnd_in;
      mod_ff  <= mod_in;
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = rem_ff[LEN_W-1:0];

endmodule

// ===== hdl/vtsec_scan_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtsec_scan_check
// Tests one word position for a removal or insertion that zeroes the
// syndrome. All partial sums stay below twice the modulus.
// ----------------------------------------------------------------------------
module vtsec_scan_check (
   input  vtsec_pkg::vtsec_scan_in_type  scan_in,
   output vtsec_pkg::vtsec_scan_out_type scan_out
);
   import vtsec_pkg::*;

   logic [LEN_W-1:0] after_ones;
   logic [LEN_W-1:0] from_ones;
   logic [MOD_W-1:0] rm_sum, rm_red;
   logic [MOD_W-1:0] s0_sum, s0_red;
   logic [MOD_W-1:0] s1_sum, s1_red;
   logic             rm_hit, hit0, hit1;

   always_comb begin
      // removal: ones strictly after this position shift down by one
      after_ones = scan_in.ones - scan_in.ones_before
                 - {{(LEN_W-1){1'b0}}, scan_in.bit_value};
      rm_sum = {1'b0, after_ones} + {1'b0, scan_in.index} + MOD_W'(1);
      rm_red = (rm_sum >= scan_in.modulus) ? rm_sum - scan_in.modulus : rm_sum;
      rm_hit = scan_in.bit_value ? (rm_red == {1'b0, scan_in.syndrome})
                                 : (after_ones == scan_in.syndrome);

      // insertion: ones at this position and after shift up by one
      from_ones = scan_in.ones - scan_in.ones_before;
      s0_sum = {1'b0, scan_in.syndrome} + {1'b0, from_ones};
      s0_red = (s0_sum >= scan_in.modulus) ? s0_sum - scan_in.modulus : s0_sum;
      hit0   = (s0_red == '0);
      s1_sum = s0_red + {1'b0, scan_in.index} + MOD_W'(1);
      s1_red = (s1_sum >= scan_in.modulus) ? s1_sum - scan_in.modulus : s1_sum;
      hit1   = (s1_red == '0);

      case (scan_in.mode)
         MODE_REMOVE: begin
            scan_out.hit      = rm_hit;
            scan_out.inserted = 1'b0;
         end
         MODE_INSERT: begin
            scan_out.hit      = hit0 | hit1;
            scan_out.inserted = ~hit0;
         end
         default: begin
            scan_out.hit      = 1'b0;
            scan_out.inserted = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/vt_code_single_error_corrector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt_code_single_error_corrector
// Varshamov-Tenengolts single-error decoder: one correction descriptor per
// received word. A 0 bit that is not the last leaves the block idle. A 1 bit
// goes through the shared modulo unit for the weighted syndrome, a single
// compare-subtract for a sum below twice n+1, else a restoring remainder. The
// last bit adds that reduction, a decide state, and for length n a single bit
// lookup, for lengths n+1 and n-1 a scan of up to n+1 positions, one per cycle
// through the registered read port of the bit store, then an emit state that
// loads the output register once it is free. The block takes no beat while a
// word's reduction or decode is in progress. No clearing pass after reset.
// ----------------------------------------------------------------------------
module vt_code_single_error_corrector (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_bit_value,
   input  logic                        req_last_bit,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [2:0]                  rsp_status,
   output logic [vtsec_pkg::LEN_W-1:0] rsp_position,
   output logic                        rsp_inserted_value,
   input  logic                        csr_write_enable,
   input  logic [vtsec_pkg::LEN_W-1:0] csr_write_data
);
   import vtsec_pkg::*;

   vtsec_state_type   state_ff, state_in;
   logic [LEN_W-1:0]  code_ff;
   logic [LEN_W-1:0]  wl_ff, wl_in;
   logic [LEN_W-1:0]  ones_ff, ones_in;
   logic [LEN_W-1:0]  syn_ff, syn_in;
   logic              last_ff, last_in;
   vtsec_mode_type    mode_ff, mode_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [LEN_W-1:0]  before_ff, before_in;
   vtsec_status_type  res_status_ff, res_status_in;
   logic [LEN_W-1:0]  res_pos_ff, res_pos_in;
   logic              res_ins_ff, res_ins_in;
   logic              rsp_valid_ff, rsp_valid_in;
   vtsec_status_type  rsp_status_ff, rsp_status_in;
   logic [LEN_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic              rsp_ins_ff, rsp_ins_in;

   logic              bits_mem [WORD_DEPTH];
   logic              rd_data_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   logic              accept;
   logic              wr_ok;
   logic              overflow;
   logic              len_eq_n, len_eq_n1, len_eq_nm1;
   logic              clear_ok;
   logic              scan_end;
   logic              out_free;
   logic [MOD_W-1:0]  modulus;
   logic [LEN_W-1:0]  next_idx;
   logic [LEN_W-1:0]  syn_m1;

   vtsec_mod_req_type  mod_req;
   vtsec_mod_rsp_type  mod_rsp;
   vtsec_scan_in_type  scan_in;
   vtsec_scan_out_type scan_out;

   vtsec_mod_reduce u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   vtsec_scan_check u_scan (
      .scan_in  (scan_in),
      .scan_out (scan_out)
   );

   assign modulus    = {1'b0, code_ff} + MOD_W'(1);
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid & ~req_stall;
   assign wr_ok      = (wl_ff < LEN_W'(WORD_DEPTH));
   assign overflow   = (wl_ff > LEN_W'(WORD_DEPTH));
   assign len_eq_n   = (wl_ff == code_ff);
   assign len_eq_n1  = ({1'b0, wl_ff} == modulus);
   assign len_eq_nm1 = (({1'b0, wl_ff} + MOD_W'(1)) == {1'b0, code_ff});
   assign syn_m1     = syn_ff - LEN_W'(1);
   assign clear_ok   = (syn_ff != '0) && (syn_ff <= wl_ff);
   assign next_idx   = idx_ff + LEN_W'(1);
   assign scan_end   = (mode_ff == MODE_REMOVE) ? (next_idx == wl_ff) : (idx_ff == wl_ff);
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;

   assign scan_in.mode        = mode_ff;
   assign scan_in.bit_value   = rd_data_ff;
   assign scan_in.syndrome    = syn_ff;
   assign scan_in.ones        = ones_ff;
   assign scan_in.ones_before = before_ff;
   assign scan_in.index       = idx_ff;
   assign scan_in.modulus     = modulus;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && ((req_bit_value && wr_ok) || req_last_bit)) begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (mod_rsp.done) begin
               state_in = last_ff ? ST_DECIDE : ST_IDLE;
            end
         end
         ST_DECIDE: begin
            if (overflow) begin
               state_in = ST_EMIT;
            end else if (len_eq_n) begin
               state_in = (syn_ff == '0) ? ST_EMIT : ST_CHECK_CLEAR;
            end else if (len_eq_n1 || len_eq_nm1) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_CHECK_CLEAR: begin
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (scan_out.hit || scan_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      wl_in         = wl_ff;
      ones_in       = ones_ff;
      syn_in        = syn_ff;
      last_in       = last_ff;
      mode_in       = mode_ff;
      idx_in        = idx_ff;
      before_in     = before_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      res_ins_in    = res_ins_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_ins_in    = rsp_ins_ff;
      mod_req.start   = 1'b0;
      mod_req.operand = {1'b0, syn_ff};
      mod_req.modulus = modulus;
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_bit;
               if (wr_ok) begin
                  wr_en = 1'b1;
                  wl_in = wl_ff + LEN_W'(1);
                  if (req_bit_value) begin
                     ones_in = ones_ff + LEN_W'(1);
                     mod_req.operand = {1'b0, syn_ff} + {1'b0, wl_ff} + MOD_W'(1);
                  end
               end else begin
                  wl_in = LEN_W'(WORD_DEPTH + 1);
               end
               mod_req.start = (req_bit_value && wr_ok) || req_last_bit;
            end
         end
         ST_REDUCE: begin
            if (mod_rsp.done) begin
               syn_in = mod_rsp.remainder;
            end
         end
         ST_DECIDE: begin
            res_status_in = STATUS_FAIL;
            res_pos_in    = '0;
            res_ins_in    = 1'b0;
            idx_in        = '0;
            before_in     = '0;
            mode_in       = len_eq_n1 ? MODE_REMOVE : MODE_INSERT;
            if (!overflow && len_eq_n) begin
               if (syn_ff == '0) begin
                  res_status_in = STATUS_OK;
               end else begin
                  rd_en   = clear_ok;
                  rd_addr = syn_m1[ADDR_W-1:0];
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = '0;
            end
         end
         ST_CHECK_CLEAR: begin
            if (clear_ok && rd_data_ff) begin
               res_status_in = STATUS_CLEAR;
               res_pos_in    = syn_m1;
            end
         end
         ST_SCAN: begin
            rd_en   = (next_idx < LEN_W'(WORD_DEPTH));
            rd_addr = next_idx[ADDR_W-1:0];
            if (scan_out.hit) begin
               res_status_in = (mode_ff == MODE_REMOVE) ? STATUS_REMOVE : STATUS_INSERT;
               res_pos_in    = idx_ff;
               res_ins_in    = scan_out.inserted;
            end else if (!scan_end) begin
               idx_in    = next_idx;
               before_in = before_ff + {{(LEN_W-1){1'b0}}, rd_data_ff};
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_ins_in    = res_ins_ff;
               wl_in         = '0;
               ones_in       = '0;
               syn_in        = '0;
            end
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   // bit store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bits_mem[wl_ff[ADDR_W-1:0]] <= req_bit_value;
      end
      if (rd_en) begin
         rd_data_ff <= bits_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         code_ff      <= LEN_W'(1);
         wl_ff        <= '0;
         ones_ff      <= '0;
         syn_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_write_enable) begin
            code_ff <= csr_write_data;
         end
         wl_ff        <= wl_in;
         ones_ff      <= ones_in;
         syn_ff       <= syn_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff       <= last_in;
      mode_ff       <= mode_in;
      idx_ff        <= idx_in;
      before_ff     <= before_in;
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      res_ins_ff    <= res_ins_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_ins_ff    <= rsp_ins_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_position       = rsp_pos_ff;
   assign rsp_inserted_value = rsp_ins_ff;

endmodule

// ===== bench/vt_code_single_error_corrector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vt_code_single_error_corrector_test
// Streams received words one bit per beat into the VT single-error corrector
// and checks every correction descriptor against a bit-accurate predictor of
// the syndrome and the decode scans. Words are mostly codewords with one
// injected flip, deletion or insertion, plus noise, over several code lengths,
// with random gaps on the bit input and random stalls on the result side.
// ----------------------------------------------------------------------------
module vt_code_single_error_corrector_test;
   import vtsec_pkg::*;

   localparam int QUIET_LIMIT = 20000;

   typedef struct packed {
      logic bit_value;
      logic last_bit;
   } serial_beat_type;

   typedef struct packed {
      vtsec_status_type status;
      logic [LEN_W-1:0] position;
      logic             inserted;
   } correction_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic             req_bit_value = 1'b0;
   logic             req_last_bit = 1'b0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [2:0]       rsp_status;
   logic [LEN_W-1:0] rsp_position;
   logic             rsp_inserted_value;
   logic             csr_write_enable = 1'b0;
   logic [LEN_W-1:0] csr_write_data = '0;

   // predictor state
   bit               stored_bits [0:MAX_LEN];
   int unsigned      rx_len = 0;
   int unsigned      rx_ones = 0;
   int unsigned      rx_syndrome = 0;
   logic [LEN_W-1:0] code_len = LEN_W'(1);

   serial_beat_type  pending_bits[$];
   correction_type   expected_corrections[$];
   bit               word_bits[$];
   logic             req_fire = 1'b0;
   int unsigned      send_idle_pct = 11;
   int unsigned      recv_idle_pct = 70;
   int               quiet_cycles = 0;
   int               fail_count = 0;

   vt_code_single_error_corrector u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_bit_value      (req_bit_value),
      .req_last_bit       (req_last_bit),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_position       (rsp_position),
      .rsp_inserted_value (rsp_inserted_value),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned mod_sum(int unsigned a, int unsigned b, int unsigned m);
      return ((a % m) + (b % m)) % m;
   endfunction

   function automatic int unsigned mod_diff(int unsigned a, int unsigned b, int unsigned m);
      int unsigned x;
      int unsigned y;
      x = a % m;
      y = b % m;
      return (x >= y) ? x - y : x + m - y;
   endfunction

   // Folds one bit into the running word; on the last bit decodes the word
   // and queues the descriptor it must produce.
   function automatic void absorb_bit(logic bit_value, logic last_bit);
      int unsigned    n, modulus, m, t, i, prior, after, d, from, s0;
      bit             found;
      correction_type corr;
      n = code_len;
      modulus = n + 1;
      if (rx_len < MAX_LEN + 1) begin
         stored_bits[rx_len] = bit_value;
         if (bit_value) begin
            rx_ones++;
            rx_syndrome = mod_sum(rx_syndrome, rx_len + 1, modulus);
         end
         rx_len++;
      end else begin
         rx_len = MAX_LEN + 2;
      end
      if (!last_bit)
         return;

      m = rx_len;
      t = rx_syndrome % modulus;
      found = 1'b0;
      corr.status = STATUS_FAIL;
      corr.position = '0;
      corr.inserted = 1'b0;
      if (m > MAX_LEN + 1) begin
         // overflowed word always fails
      end else if (m == n) begin
         if (t == 0) begin
            corr.status = STATUS_OK;
         end else begin
            for (i = 0; i < m && !found; i++) begin
               if (stored_bits[i] && mod_diff(t, i + 1, modulus) == 0) begin
                  corr.status = STATUS_CLEAR;
                  corr.position = LEN_W'(i);
                  found = 1'b1;
               end
            end
         end
      end else if (m == n + 1) begin
         prior = 0;
         for (i = 0; i < m && !found; i++) begin
            after = rx_ones - prior - stored_bits[i];
            d = mod_diff(t, after, modulus);
            if (stored_bits[i])
               d = mod_diff(d, i + 1, modulus);
            if (d == 0) begin
               corr.status = STATUS_REMOVE;
               corr.position = LEN_W'(i);
               found = 1'b1;
            end
            prior += stored_bits[i];
         end
      end else if (m + 1 == n) begin
         prior = 0;
         for (i = 0; i <= m && !found; i++) begin
            from = rx_ones - prior;
            s0 = mod_sum(t, from, modulus);
            if (s0 == 0) begin
               corr.status = STATUS_INSERT;
               corr.position = LEN_W'(i);
               found = 1'b1;
            end else if (mod_sum(s0, i + 1, modulus) == 0) begin
               corr.status = STATUS_INSERT;
               corr.position = LEN_W'(i);
               corr.inserted = 1'b1;
               found = 1'b1;
            end
            if (i < m)
               prior += stored_bits[i];
         end
      end
      expected_corrections.push_back(corr);
      rx_len = 0;
      rx_ones = 0;
      rx_syndrome = 0;
   endfunction

   // bit driver: a new beat only after the current one was taken
   always @(negedge clock) begin : bit_driver
      serial_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (pending_bits.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            beat = pending_bits.pop_front();
            req_valid <= 1'b1;
            req_bit_value <= beat.bit_value;
            req_last_bit <= beat.last_bit;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      correction_type want;
      if (reset) begin
         req_fire <= 1'b0;
         quiet_cycles <= 0;
         rx_len = 0;
         rx_ones = 0;
         rx_syndrome = 0;
         code_len = LEN_W'(1);
      end else begin
         req_fire <= req_valid && !req_stall;
         if (csr_write_enable)
            code_len = csr_write_data;
         if (req_valid && !req_stall)
            absorb_bit(req_bit_value, req_last_bit);
         if (rsp_valid && !rsp_stall) begin
            if (expected_corrections.size() == 0) begin
               $error("result beat with no word outstanding: status %0d position %0d",
                      rsp_status, rsp_position);
               fail_count++;
            end else begin
               want = expected_corrections.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  fail_count++;
               end
               if (rsp_inserted_value !== want.inserted) begin
                  $error("inserted_value: expected %0d, got %0d", want.inserted,
                         rsp_inserted_value);
                  fail_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("vt_code_single_error_corrector test failed");
         $finish;
      end
   end

   // Waits for all queued bits and descriptors, then for the longest scan.
   task automatic wait_drained();
      do
         @(posedge clock);
      while (pending_bits.size() != 0 || req_valid || expected_corrections.size() != 0);
      repeat (int'(code_len) + 64) @(posedge clock);
   endtask

   task automatic set_code_length(input logic [LEN_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_word(input bit mark_last);
      int i;
      for (i = 0; i < word_bits.size(); i++)
         pending_bits.push_back({word_bits[i], mark_last && (i == word_bits.size() - 1)});
   endtask

   // pattern is sent MSB first
   task automatic queue_literal(input logic [15:0] pattern, input int len, input bit mark_last);
      int i;
      word_bits.delete();
      for (i = len - 1; i >= 0; i--)
         word_bits.push_back(pattern[i]);
      queue_word(mark_last);
   endtask

   function automatic int unsigned word_weight(int unsigned modulus);
      int unsigned sum;
      int          i;
      sum = 0;
      for (i = 0; i < word_bits.size(); i++)
         if (word_bits[i])
            sum = (sum + i + 1) % modulus;
      return sum;
   endfunction

   // Random n-bit word driven to syndrome zero by setting or clearing single bits.
   task automatic build_codeword(input int unsigned n);
      int unsigned s, d, tries;
      word_bits.delete();
      repeat (n) word_bits.push_back(bit'($urandom_range(0, 1)));
      for (tries = 0; tries < 500; tries++) begin
         s = word_weight(n + 1);
         if (s == 0)
            break;
         d = n + 1 - s;
         if (!word_bits[d - 1])
            word_bits[d - 1] = 1'b1;
         else if (word_bits[s - 1])
            word_bits[s - 1] = 1'b0;
         else
            word_bits[$urandom_range(0, n - 1)] ^= 1'b1;
      end
   endtask

   function automatic void flip_one(bit from_value);
      int unsigned start, k, idx;
      start = $urandom_range(0, word_bits.size() - 1);
      for (k = 0; k < word_bits.size(); k++) begin
         idx = (start + k) % word_bits.size();
         if (word_bits[idx] == from_value) begin
            word_bits[idx] = !from_value;
            break;
         end
      end
   endfunction

   task automatic queue_random_word(input int unsigned n, inout int unsigned items);
      int unsigned kind, idx, len;
      kind = $urandom_range(0, 9);
      build_codeword(n);
      case (kind)
         2, 3: flip_one(1'b0);
         4, 5: word_bits.delete($urandom_range(0, n - 1));
         6, 7: begin
            idx = $urandom_range(0, n);
            if (idx == word_bits.size())
               word_bits.push_back(bit'($urandom_range(0, 1)));
            else
               word_bits.insert(idx, bit'($urandom_range(0, 1)));
         end
         8: flip_one(1'b1);
         9: begin
            word_bits.delete();
            len = $urandom_range(1, n + 3);
            repeat (len) word_bits.push_back(bit'($urandom_range(0, 1)));
         end
         default: ;
      endcase
      if (word_bits.size() == 0)
         word_bits.push_back(bit'($urandom_range(0, 1)));
      items += word_bits.size();
      queue_word(1'b1);
   endtask

   initial begin : stimulus
      int unsigned profile, setting, items, n;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset length of one: clear, clean, remove, wrong length
      queue_literal(16'b1, 1, 1'b1);
      queue_literal(16'b0, 1, 1'b1);
      queue_literal(16'b11, 2, 1'b1);
      queue_literal(16'b000, 3, 1'b1);
      // length changed in the middle of a word
      queue_literal(16'b1, 1, 1'b0);
      set_code_length(LEN_W'(2));
      queue_literal(16'b1, 1, 1'b1);
      queue_literal(16'b1, 1, 1'b1);
      // modulus of one: any single bit is removable
      set_code_length(LEN_W'(0));
      queue_literal(16'b1, 1, 1'b1);
      queue_literal(16'b0, 1, 1'b1);
      set_code_length(11'h7FF);
      queue_literal(16'b10, 2, 1'b1);
      set_code_length(LEN_W'(4));
      queue_literal(16'b0110, 4, 1'b1);
      queue_literal(16'b1110, 4, 1'b1);

      for (profile = 0; profile < 3; profile++) begin
         for (setting = 0; setting < 4; setting++) begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 16);
            if (profile == 1 && setting == 0)
               n = 1;
            set_code_length(LEN_W'(n));
            if (setting == 0) begin
               send_idle_pct = (profile == 0) ? 11 : (profile == 1) ? 70 : 0;
               recv_idle_pct = (profile == 0) ? 70 : (profile == 1) ? 11 : 0;
            end
            items = 0;
            while (items < 50)
               queue_random_word(n, items);
         end
      end

      wait_drained();
      if (fail_count == 0)
         $display("vt_code_single_error_corrector test passed");
      else
         $display("vt_code_single_error_corrector test failed");
      $finish;
   end

endmodule
